// ===== hdl/tesp_pkg.sv =====
// Shared constants, codes and the result record of the tree entry stream parser.
`default_nettype none
package tesp_pkg;

    localparam int MAX_ENTRIES      = 1024;
    localparam int NAME_CAPACITY    = 256;
    localparam int HASH_BYTES       = 32;
    localparam int MODE_FIELD_LIMIT = 16;

    localparam int MODE_LEN_W  = $clog2(MODE_FIELD_LIMIT);
    localparam int NAME_LEN_W  = $clog2(NAME_CAPACITY);
    localparam int HASH_CNT_W  = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;
    localparam int ENTRY_CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int MODE_W      = 32;

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_NUL   = 8'h00;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_SEVEN = 8'h37;

    typedef enum logic [2:0] {
        KIND_IGNORED   = 3'd0,
        KIND_MODE      = 3'd1,
        KIND_SEPARATOR = 3'd2,
        KIND_NAME      = 3'd3,
        KIND_HASH      = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        END_RUN = 2'd0,
        END_OK  = 2'd1,
        END_ERR = 2'd2
    } t_end;

    typedef struct packed {
        t_kind                    kind;
        logic [7:0]               byte_echo;
        logic [7:0]               position;
        logic [9:0]               entry_index;
        logic                     entry_done;
        logic [MODE_W-1:0]        mode_value;
        t_end                     end_code;
        logic [ENTRY_CNT_W-1:0]   entry_count;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/tesp_if.sv =====
// Valid/ready channel interfaces for input bytes and parse results.
`default_nettype none
interface tesp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;
    logic       final_byte;

    modport source (output valid, output data_byte, output first, output final_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input first, input final_byte,
                    output ready);
endinterface

interface tesp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  byte_echo;
    logic [7:0]  position;
    logic [9:0]  entry_index;
    logic        entry_done;
    logic [31:0] mode_value;
    logic        finished;
    logic        status;
    logic [10:0] entries_total;
    logic        table_full;

    modport source (output valid, output kind, output byte_echo, output position,
                    output entry_index, output entry_done, output mode_value,
                    output finished, output status, output entries_total,
                    output table_full, input ready);
    modport sink   (input valid, input kind, input byte_echo, input position,
                    input entry_index, input entry_done, input mode_value,
                    input finished, input status, input entries_total,
                    input table_full, output ready);
endinterface
`default_nettype wire

// ===== hdl/tesp_front.sv =====
// Front end: accepts bytes, classifies them and advances the entry parse state.
`default_nettype none
module tesp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    tesp_in_if.sink            i_in,
    input  wire logic          i_q_ready,
    output logic               o_q_push,
    output tesp_pkg::t_result  o_q_data
);
    import tesp_pkg::*;

    typedef enum logic [2:0] {
        PH_MODE,
        PH_NAME,
        PH_HASH,
        PH_FULL,
        PH_DONE_OK,
        PH_DONE_ERR
    } t_phase;

    localparam logic [MODE_LEN_W-1:0]  MODE_LEN_LAST  = MODE_LEN_W'(MODE_FIELD_LIMIT - 1);
    localparam logic [NAME_LEN_W-1:0]  NAME_LEN_LAST  = NAME_LEN_W'(NAME_CAPACITY - 1);
    localparam logic [HASH_CNT_W-1:0]  HASH_CNT_LAST  = HASH_CNT_W'(HASH_BYTES - 1);
    localparam logic [ENTRY_CNT_W-1:0] ENTRY_CNT_LAST = ENTRY_CNT_W'(MAX_ENTRIES - 1);

    t_phase                   r_phase,  n_phase,  c_phase;
    logic [MODE_W-1:0]        r_acc,    n_acc,    c_acc;
    logic                     r_stop,   n_stop,   c_stop;
    logic [MODE_LEN_W-1:0]    r_mlen,   n_mlen,   c_mlen;
    logic [NAME_LEN_W-1:0]    r_nlen,   n_nlen,   c_nlen;
    logic [HASH_CNT_W-1:0]    r_hcnt,   n_hcnt,   c_hcnt;
    logic [ENTRY_CNT_W-1:0]   r_ecnt,   n_ecnt,   c_ecnt;

    t_kind                    kind;
    logic [7:0]               pos;
    logic                     done;
    logic                     err;
    logic                     boundary;
    logic [MODE_W-1:0]        mode_out;

    always_comb begin
        c_phase = r_phase;
        c_acc   = r_acc;
        c_stop  = r_stop;
        c_mlen  = r_mlen;
        c_nlen  = r_nlen;
        c_hcnt  = r_hcnt;
        c_ecnt  = r_ecnt;
        if (i_in.first) begin
            c_phase = PH_MODE;
            c_acc   = '0;
            c_stop  = 1'b0;
            c_mlen  = '0;
            c_nlen  = '0;
            c_hcnt  = '0;
            c_ecnt  = '0;
        end

        n_phase  = c_phase;
        n_acc    = c_acc;
        n_stop   = c_stop;
        n_mlen   = c_mlen;
        n_nlen   = c_nlen;
        n_hcnt   = c_hcnt;
        n_ecnt   = c_ecnt;
        kind     = KIND_IGNORED;
        pos      = '0;
        done     = 1'b0;
        err      = 1'b0;
        boundary = 1'b0;
        mode_out = c_acc;

        case (c_phase)
            PH_MODE: begin
                if (i_in.data_byte == ASCII_SPACE) begin
                    kind    = KIND_SEPARATOR;
                    n_phase = PH_NAME;
                end else begin
                    kind = KIND_MODE;
                    pos  = 8'(c_mlen);
                    if (!c_stop && (i_in.data_byte inside {[ASCII_ZERO:ASCII_SEVEN]})) begin
                        n_acc = {c_acc[MODE_W-4:0], i_in.data_byte[2:0]};
                    end else begin
                        n_stop = 1'b1;
                    end
                    if (c_mlen == MODE_LEN_LAST) begin
                        err = 1'b1;
                    end else begin
                        n_mlen = c_mlen + 1'b1;
                    end
                end
                mode_out = n_acc;
            end
            PH_NAME: begin
                if (i_in.data_byte == ASCII_NUL) begin
                    kind    = KIND_SEPARATOR;
                    n_phase = PH_HASH;
                end else begin
                    kind = KIND_NAME;
                    pos  = 8'(c_nlen);
                    if (c_nlen == NAME_LEN_LAST) begin
                        err = 1'b1;
                    end else begin
                        n_nlen = c_nlen + 1'b1;
                    end
                end
            end
            PH_HASH: begin
                kind = KIND_HASH;
                pos  = 8'(c_hcnt);
                if (c_hcnt == HASH_CNT_LAST) begin
                    done    = 1'b1;
                    n_ecnt  = c_ecnt + 1'b1;
                    n_acc   = '0;
                    n_stop  = 1'b0;
                    n_mlen  = '0;
                    n_nlen  = '0;
                    n_hcnt  = '0;
                    n_phase = (c_ecnt == ENTRY_CNT_LAST) ? PH_FULL : PH_MODE;
                end else begin
                    n_hcnt = c_hcnt + 1'b1;
                end
            end
            default: ;
        endcase

        if (err) begin
            n_phase = PH_DONE_ERR;
        end else if (i_in.final_byte && (n_phase != PH_DONE_OK) && (n_phase != PH_DONE_ERR)) begin
            boundary = (n_phase == PH_FULL) || ((n_phase == PH_MODE) && (n_mlen == '0));
            n_phase  = boundary ? PH_DONE_OK : PH_DONE_ERR;
        end
    end

    assign i_in.ready = i_q_ready;
    assign o_q_push   = i_in.valid && i_q_ready;

    always_comb begin
        o_q_data.kind        = kind;
        o_q_data.byte_echo   = i_in.data_byte;
        o_q_data.position    = pos;
        o_q_data.entry_index = 10'(c_ecnt);
        o_q_data.entry_done  = done;
        o_q_data.mode_value  = mode_out;
        o_q_data.entry_count = n_ecnt;
        case (n_phase)
            PH_DONE_OK:  o_q_data.end_code = END_OK;
            PH_DONE_ERR: o_q_data.end_code = END_ERR;
            default:     o_q_data.end_code = END_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MODE;
            r_acc   <= '0;
            r_stop  <= 1'b0;
            r_mlen  <= '0;
            r_nlen  <= '0;
            r_hcnt  <= '0;
            r_ecnt  <= '0;
        end else if (o_q_push) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_stop  <= n_stop;
            r_mlen  <= n_mlen;
            r_nlen  <= n_nlen;
            r_hcnt  <= n_hcnt;
            r_ecnt  <= n_ecnt;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/tesp_queue.sv =====
// Two-entry queue of classified results between the front and back ends.
`default_nettype none
module tesp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tesp_pkg::t_result i_data,
    output logic               o_ready,
    output logic               o_valid,
    output tesp_pkg::t_result  o_data,
    input  wire logic          i_pop
);
    import tesp_pkg::*;

    t_result     r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count,  n_count;
    logic        do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/tesp_back.sv =====
// Back end: output register that decodes parse status and drives the result channel.
`default_nettype none
module tesp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire tesp_pkg::t_result i_q_data,
    output logic               o_q_pop,
    tesp_out_if.source         o_out
);
    import tesp_pkg::*;

    localparam logic [ENTRY_CNT_W-1:0] ENTRY_LIMIT = ENTRY_CNT_W'(MAX_ENTRIES);

    logic     r_valid;
    t_result  r_beat;
    logic     load;

    assign load    = !r_valid || o_out.ready;
    assign o_q_pop = load && i_q_valid;

    assign o_out.valid         = r_valid;
    assign o_out.kind          = r_beat.kind;
    assign o_out.byte_echo     = r_beat.byte_echo;
    assign o_out.position      = r_beat.position;
    assign o_out.entry_index   = r_beat.entry_index;
    assign o_out.entry_done    = r_beat.entry_done;
    assign o_out.mode_value    = r_beat.mode_value;
    assign o_out.finished      = (r_beat.end_code != END_RUN);
    assign o_out.status        = (r_beat.end_code == END_ERR);
    assign o_out.entries_total = 11'(r_beat.entry_count);
    assign o_out.table_full    = (r_beat.entry_count >= ENTRY_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_beat <= i_q_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/tree_entry_stream_parser.sv =====
// Top level of the tree entry stream parser: front end, result queue and output stage.
// Throughput: one byte per clock, sustained, while the result side keeps taking beats.
// A result beat is offered only after the queue write and then the output register load
// that follow the acceptance of its byte.
// Up to three results (two queued, one held at the output) ride out a stalled result side.
// Synchronous active-low reset clears the parse state, queue pointers and output valid.
`default_nettype none
module tree_entry_stream_parser (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tesp_in_if.sink    i_in,
    tesp_out_if.source o_out
);
    import tesp_pkg::*;

    logic     q_ready;
    logic     q_push;
    t_result  q_wdata;
    logic     q_valid;
    t_result  q_rdata;
    logic     q_pop;

    tesp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    tesp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .i_pop   (q_pop)
    );

    tesp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

// ===== hdl/tesp_checker.sv =====
// Port-level checks on the parser's result channel, bound to the top level.
`default_nettype none
module tesp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  i_kind,
    input wire logic [7:0]  i_position,
    input wire logic        i_entry_done,
    input wire logic        i_finished,
    input wire logic        i_status,
    input wire logic [10:0] i_entries_total,
    input wire logic        i_table_full
);
    import tesp_pkg::*;

    a_status_needs_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status |-> i_finished)
        else $error("error status without finished");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_table_full |-> i_entries_total == 11'(MAX_ENTRIES))
        else $error("table full with wrong entry total");

    a_done_on_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_entry_done |-> i_kind == KIND_HASH)
        else $error("entry done on a non-hash beat");

    a_sep_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_SEPARATOR || i_kind == KIND_IGNORED) |-> i_position == 8'd0)
        else $error("nonzero position on separator or ignored beat");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_position))
        else $error("result beat changed while stalled");

endmodule

bind tree_entry_stream_parser tesp_checker u_tesp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_out.valid),
    .i_ready         (o_out.ready),
    .i_kind          (o_out.kind),
    .i_position      (o_out.position),
    .i_entry_done    (o_out.entry_done),
    .i_finished      (o_out.finished),
    .i_status        (o_out.status),
    .i_entries_total (o_out.entries_total),
    .i_table_full    (o_out.table_full)
);
`default_nettype wire
